### sv/hlpd_pkg.sv
// hlpd_pkg: shared constants, codes and transfer structs of the hold list packet deframer
// no dependencies
`default_nettype none

package hlpd_pkg;

	localparam int MAX_HOLDS = 512;
	localparam int ADDR_W    = $clog2(MAX_HOLDS);
	localparam int CNT_W     = $clog2(MAX_HOLDS + 1);

	localparam logic [7:0] START_BYTE   = 8'd1;
	localparam logic [8:0] LENGTH_EXTRA = 9'd5;
	localparam logic [7:0] LAST_CMD_A   = 8'd84;
	localparam logic [7:0] LAST_CMD_B   = 8'd83;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		EV_TAKEN     = 3'd0,
		EV_BAD_START = 3'd1,
		EV_SUM_FAIL  = 3'd2,
		EV_PKT_OK    = 3'd3,
		EV_PKT_LAST  = 3'd4,
		EV_READ_OK   = 3'd5,
		EV_READ_OOR  = 3'd6,
		EV_CLEARED   = 3'd7
	} event_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [15:0]       position;
		logic [7:0]        color;
	} tbl_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		event_t           ev;
		logic [CNT_W-1:0] count;
		logic             complete;
		logic             overflow;
	} step_res_t;

endpackage

`default_nettype wire

### sv/hlpd_table.sv
// hlpd_table: hold table ram, position and color per entry, one write and one registered read
// depends on hlpd_pkg
`default_nettype none

module hlpd_table (
	input  wire logic             clk,
	input  wire hlpd_pkg::tbl_wr_t wr,
	input  wire hlpd_pkg::tbl_rd_t rd,
	output logic [15:0]           rd_position,
	output logic [7:0]            rd_color
);
	import hlpd_pkg::*;

	logic [23:0] mem [MAX_HOLDS];
	logic [23:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.position, wr.color};
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_position = rd_data_q[23:8];
	assign rd_color    = rd_data_q[7:0];

endmodule

`default_nettype wire

### sv/hlpd_parser.sv
// hlpd_parser: packet framing state, checksum, record assembly and table bookkeeping
// depends on hlpd_pkg; drives the write and read ports of hlpd_table
`default_nettype none

module hlpd_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [1:0]            opcode,
	input  wire logic [7:0]            data_byte,
	input  wire logic [8:0]            hold_index,
	output hlpd_pkg::tbl_wr_t          wr,
	output hlpd_pkg::tbl_rd_t          rd,
	output hlpd_pkg::step_res_t        res
);
	import hlpd_pkg::*;

	logic [8:0]       pos_q,   pos_n;
	logic [8:0]       len_q,   len_n;
	logic [7:0]       esum_q,  esum_n;
	logic [7:0]       sum_q,   sum_n;
	logic [7:0]       cmd_q,   cmd_n;
	logic [7:0]       low_q,   low_n;
	logic [7:0]       high_q,  high_n;
	logic [1:0]       phase_q, phase_n;
	logic [9:0]       pend_q,  pend_n;
	logic [CNT_W-1:0] cnt_q,   cnt_n;
	logic             cmpl_q,  cmpl_n;
	logic             ovf_q,   ovf_n;
	event_t           ev;
	logic [9:0]       p10;
	logic [9:0]       len10;
	logic [CNT_W:0]   slot;
	logic [CNT_W:0]   room;

	always_comb begin
		pos_n   = pos_q;
		len_n   = len_q;
		esum_n  = esum_q;
		sum_n   = sum_q;
		cmd_n   = cmd_q;
		low_n   = low_q;
		high_n  = high_q;
		phase_n = phase_q;
		pend_n  = pend_q;
		cnt_n   = cnt_q;
		cmpl_n  = cmpl_q;
		ovf_n   = ovf_q;
		ev      = EV_TAKEN;
		wr      = '0;
		rd      = '0;
		p10     = {1'b0, pos_q};
		len10   = {1'b0, len_q};
		slot    = '0;
		room    = '0;
		case (opcode_t'(opcode))
			OP_PUSH: begin
				if (cmpl_q) begin
					cnt_n  = '0;
					cmpl_n = 1'b0;
					ovf_n  = 1'b0;
				end
				if (pos_q == 9'd0 && data_byte != START_BYTE) begin
					pos_n   = '0;
					len_n   = '0;
					esum_n  = '0;
					sum_n   = '0;
					cmd_n   = '0;
					low_n   = '0;
					high_n  = '0;
					phase_n = '0;
					pend_n  = '0;
					ev      = EV_BAD_START;
				end else begin
					pos_n = pos_q + 9'd1;
					if (pos_q == 9'd1) begin
						len_n = {1'b0, data_byte} + LENGTH_EXTRA;
					end else if (pos_q == 9'd2) begin
						esum_n = data_byte;
					end else if (pos_q >= 9'd3) begin
						if (pos_q >= 9'd4 && p10 + 10'd2 <= len10) begin
							sum_n = sum_q + data_byte;
						end
						if (pos_q == 9'd4) begin
							cmd_n = data_byte;
						end
						if (pos_q >= 9'd5 && p10 + 10'd1 <= len10) begin
							case (phase_q)
								2'd0: begin
									low_n   = data_byte;
									phase_n = 2'd1;
								end
								2'd1: begin
									high_n  = data_byte;
									phase_n = 2'd2;
								end
								default: begin
									slot        = {1'b0, cnt_n} + {1'b0, pend_n};
									wr.en       = slot < (CNT_W+1)'(MAX_HOLDS);
									wr.addr     = slot[ADDR_W-1:0];
									wr.position = {high_n, low_n};
									wr.color    = data_byte;
									pend_n      = pend_n + 10'd1;
									phase_n     = 2'd0;
								end
							endcase
						end
						if (p10 + 10'd1 == len10) begin
							// trailing partial record gets color zero
							if (phase_n == 2'd2) begin
								slot        = {1'b0, cnt_n} + {1'b0, pend_n};
								wr.en       = slot < (CNT_W+1)'(MAX_HOLDS);
								wr.addr     = slot[ADDR_W-1:0];
								wr.position = {high_n, low_n};
								wr.color    = 8'd0;
								pend_n      = pend_n + 10'd1;
								phase_n     = 2'd0;
							end
							if (~sum_n == esum_q) begin
								room = (CNT_W+1)'(MAX_HOLDS) - {1'b0, cnt_n};
								if ((CNT_W+1)'(pend_n) > room) begin
									cnt_n = CNT_W'(MAX_HOLDS);
									ovf_n = 1'b1;
								end else begin
									cnt_n = cnt_n + CNT_W'(pend_n);
								end
								cmpl_n = (cmd_n == LAST_CMD_A) || (cmd_n == LAST_CMD_B);
								ev     = cmpl_n ? EV_PKT_LAST : EV_PKT_OK;
							end else begin
								ev = EV_SUM_FAIL;
							end
							pos_n   = '0;
							len_n   = '0;
							esum_n  = '0;
							sum_n   = '0;
							cmd_n   = '0;
							low_n   = '0;
							high_n  = '0;
							phase_n = '0;
							pend_n  = '0;
						end
					end
				end
			end
			OP_READ: begin
				rd.en   = 1'b1;
				rd.addr = hold_index;
				ev      = (CNT_W'(hold_index) < cnt_q) ? EV_READ_OK : EV_READ_OOR;
			end
			OP_CLEAR: begin
				cnt_n   = '0;
				cmpl_n  = 1'b0;
				ovf_n   = 1'b0;
				pos_n   = '0;
				len_n   = '0;
				esum_n  = '0;
				sum_n   = '0;
				cmd_n   = '0;
				low_n   = '0;
				high_n  = '0;
				phase_n = '0;
				pend_n  = '0;
				ev      = EV_CLEARED;
			end
			default: begin
				ev = EV_TAKEN;
			end
		endcase
		if (!accept) begin
			wr = '0;
			rd = '0;
		end
		res = '{ev: ev, count: cnt_n, complete: cmpl_n, overflow: ovf_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			esum_q  <= '0;
			sum_q   <= '0;
			cmd_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			phase_q <= '0;
			pend_q  <= '0;
			cnt_q   <= '0;
			cmpl_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_n;
			len_q   <= len_n;
			esum_q  <= esum_n;
			sum_q   <= sum_n;
			cmd_q   <= cmd_n;
			low_q   <= low_n;
			high_q  <= high_n;
			phase_q <= phase_n;
			pend_q  <= pend_n;
			cnt_q   <= cnt_n;
			cmpl_q  <= cmpl_n;
			ovf_q   <= ovf_n;
		end
	end

endmodule

`default_nettype wire

### sv/hold_list_packet_deframer_top.sv
// hold_list_packet_deframer_top: input handshake, table read stage and output register
// depends on hlpd_pkg, hlpd_parser and hlpd_table
`default_nettype none

// Takes one transfer per clock cycle while in_stall is low, link bytes, table reads and
// clears alike, and returns one result per transfer in order, through the table read
// stage and the output register. The framing and checksum state advances once per
// accepted byte, and each byte writes at most one entry of the 512-entry hold table
// RAM, whose read port is registered. The table needs no clearing pass after reset:
// only entries below the hold count are ever returned, and those have been written.
module hold_list_packet_deframer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  data_byte,
	input  wire logic [8:0]  hold_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_code,
	output logic [9:0]       hold_count,
	output logic             set_complete,
	output logic [15:0]      hold_position,
	output logic [7:0]       hold_color,
	output logic             table_overflow
);
	import hlpd_pkg::*;

	logic      accept;
	logic      out_free;
	tbl_wr_t   wr;
	tbl_rd_t   rd;
	step_res_t res;
	step_res_t res_s1;
	logic      valid_s1;
	logic      out_valid_q;
	logic [15:0] rd_position;
	logic [7:0]  rd_color;
	logic [2:0]  event_q;
	logic [9:0]  count_q;
	logic        complete_q;
	logic        overflow_q;
	logic [15:0] position_q;
	logic [7:0]  color_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	hlpd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.hold_index (hold_index),
		.wr         (wr),
		.rd         (rd),
		.res        (res)
	);

	hlpd_table u_table (
		.clk         (clk),
		.wr          (wr),
		.rd          (rd),
		.rd_position (rd_position),
		.rd_color    (rd_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (out_free && valid_s1) begin
			event_q    <= res_s1.ev;
			count_q    <= res_s1.count;
			complete_q <= res_s1.complete;
			overflow_q <= res_s1.overflow;
			position_q <= (res_s1.ev == EV_READ_OK) ? rd_position : 16'd0;
			color_q    <= (res_s1.ev == EV_READ_OK) ? rd_color : 8'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_code     = event_q;
	assign hold_count     = count_q;
	assign set_complete   = complete_q;
	assign hold_position  = position_q;
	assign hold_color     = color_q;
	assign table_overflow = overflow_q;

endmodule

`default_nettype wire

### verif/hlpd_checker.sv
// hlpd_checker: watches both channels of the hold list packet deframer, predicts each result
// and compares it with what the block returns; depends on hlpd_pkg
`default_nettype none

module hlpd_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  data_byte,
	input  wire logic [8:0]  hold_index,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  event_code,
	input  wire logic [9:0]  hold_count,
	input  wire logic        set_complete,
	input  wire logic [15:0] hold_position,
	input  wire logic [7:0]  hold_color,
	input  wire logic        table_overflow,
	output int unsigned      errors,
	output int unsigned      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import hlpd_pkg::*;

	typedef struct {
		event_t      ev;
		logic [9:0]  count;
		logic        done;
		logic [15:0] pos;
		logic [7:0]  col;
		logic        ovf;
	} hold_result_t;

	hold_result_t awaited_results[$];
	int unsigned mismatches;

	logic [8:0]  frame_pos;
	logic [8:0]  frame_len;
	logic [7:0]  sum_sent;
	logic [7:0]  sum_run;
	logic [7:0]  cmd_byte;
	logic [7:0]  rec_lo;
	logic [7:0]  rec_hi;
	logic [1:0]  rec_phase;
	logic [9:0]  rec_pending;
	logic [9:0]  held;
	logic        set_done;
	logic        ovf_seen;
	logic [15:0] pos_mem [MAX_HOLDS];
	logic [7:0]  col_mem [MAX_HOLDS];

	function automatic void abandon_frame();
		frame_pos = '0;
		frame_len = '0;
		sum_sent = '0;
		sum_run = '0;
		cmd_byte = '0;
		rec_lo = '0;
		rec_hi = '0;
		rec_phase = '0;
		rec_pending = '0;
	endfunction

	function automatic void forget_holds();
		held = '0;
		set_done = 1'b0;
		ovf_seen = 1'b0;
	endfunction

	// records land in the table right away, the count only moves on a good checksum
	function automatic void store_record(logic [7:0] color);
		int slot;
		slot = int'(held) + int'(rec_pending);
		if (slot < MAX_HOLDS) begin
			pos_mem[slot] = {rec_hi, rec_lo};
			col_mem[slot] = color;
		end
		rec_pending = rec_pending + 10'd1;
		rec_phase = 2'd0;
	endfunction

	function automatic event_t take_link_byte(logic [7:0] b);
		int p;
		int room;
		p = int'(frame_pos);
		if (set_done)
			forget_holds();
		if (p == 0 && b != START_BYTE) begin
			abandon_frame();
			return EV_BAD_START;
		end
		frame_pos = frame_pos + 9'd1;
		if (p == 1) begin
			frame_len = b + LENGTH_EXTRA;
			return EV_TAKEN;
		end
		if (p == 2) begin
			sum_sent = b;
			return EV_TAKEN;
		end
		if (p < 3)
			return EV_TAKEN;
		if (p >= 4 && p + 2 <= int'(frame_len))
			sum_run = sum_run + b;
		if (p == 4)
			cmd_byte = b;
		if (p >= 5 && p + 1 <= int'(frame_len)) begin
			if (rec_phase == 2'd0) begin
				rec_lo = b;
				rec_phase = 2'd1;
			end else if (rec_phase == 2'd1) begin
				rec_hi = b;
				rec_phase = 2'd2;
			end else begin
				store_record(b);
			end
		end
		if (p + 1 == int'(frame_len)) begin
			event_t ev;
			// partial record at the tail gets color zero
			if (rec_phase == 2'd2)
				store_record(8'd0);
			if (8'(~sum_run) == sum_sent) begin
				room = MAX_HOLDS - int'(held);
				if (int'(rec_pending) > room) begin
					held = 10'(MAX_HOLDS);
					ovf_seen = 1'b1;
				end else begin
					held = held + rec_pending;
				end
				set_done = (cmd_byte == LAST_CMD_A) || (cmd_byte == LAST_CMD_B);
				ev = set_done ? EV_PKT_LAST : EV_PKT_OK;
			end else begin
				ev = EV_SUM_FAIL;
			end
			abandon_frame();
			return ev;
		end
		return EV_TAKEN;
	endfunction

	function automatic hold_result_t predict_event(opcode_t op, logic [7:0] b, logic [8:0] ix);
		hold_result_t r;
		r.pos = '0;
		r.col = '0;
		case (op)
			OP_PUSH: r.ev = take_link_byte(b);
			OP_READ: begin
				if (ix < held) begin
					r.ev = EV_READ_OK;
					r.pos = pos_mem[ix];
					r.col = col_mem[ix];
				end else begin
					r.ev = EV_READ_OOR;
				end
			end
			OP_CLEAR: begin
				forget_holds();
				abandon_frame();
				r.ev = EV_CLEARED;
			end
			default: r.ev = EV_TAKEN;
		endcase
		r.count = held;
		r.done = set_done;
		r.ovf = ovf_seen;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abandon_frame();
			forget_holds();
			awaited_results.delete();
			mismatches = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result transfer: ev=%0d cnt=%0d", event_code, hold_count);
					mismatches++;
				end else begin
					hold_result_t exp_r;
					exp_r = awaited_results.pop_front();
					if (event_code !== exp_r.ev || hold_count !== exp_r.count
							|| set_complete !== exp_r.done || hold_position !== exp_r.pos
							|| hold_color !== exp_r.col || table_overflow !== exp_r.ovf) begin
						if (mismatches < 10)
							$display({"mismatch: expected ev=%0d cnt=%0d done=%0d pos=%h col=%h ovf=%0d,",
								" got ev=%0d cnt=%0d done=%0d pos=%h col=%h ovf=%0d"},
								exp_r.ev, exp_r.count, exp_r.done, exp_r.pos, exp_r.col, exp_r.ovf,
								event_code, hold_count, set_complete, hold_position, hold_color,
								table_overflow);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(predict_event(opcode_t'(opcode), data_byte, hold_index));
			errors <= mismatches;
			pending <= awaited_results.size();
		end
	end

endmodule

`default_nettype wire

### verif/tb_top.sv
// tb_top: stimulus and verdict for the hold list packet deframer
// depends on hlpd_pkg, hold_list_packet_deframer_top and hlpd_checker
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hlpd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_PUSH;
	logic [7:0]  data_byte = 8'd0;
	logic [8:0]  hold_index = 9'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_code;
	logic [9:0]  hold_count;
	logic        set_complete;
	logic [15:0] hold_position;
	logic [7:0]  hold_color;
	logic        table_overflow;
	int unsigned errors;
	int unsigned pending;

	int send_idle = 0;
	int recv_idle = 0;
	int items_sent = 0;

	hold_list_packet_deframer_top dut (.*);
	hlpd_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle);

	task automatic send_item(input opcode_t op, input logic [7:0] b, input logic [8:0] ix);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		hold_index <= ix;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op != OP_NONE)
			items_sent++;
	endtask

	// cut > 0 and below the frame length truncates the frame after that many bytes
	task automatic send_packet(input int n, input logic [7:0] cmd, input bit bad_sum, input int cut);
		logic [7:0] frame [$];
		logic [7:0] acc;
		int len;
		len = n + 5;
		acc = 8'd0;
		for (int i = 0; i < len; i++)
			frame.push_back(8'($urandom));
		frame[0] = START_BYTE;
		frame[1] = 8'(n);
		frame[4] = cmd;
		for (int i = 4; i <= len - 2; i++)
			acc = acc + frame[i];
		frame[2] = ~acc ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00);
		if (cut > 0 && cut < len)
			len = cut;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 4)
				send_item(OP_READ, 8'($urandom), 9'($urandom_range(0, 40)));
			send_item(OP_PUSH, frame[i], 9'($urandom));
		end
	endtask

	task automatic random_traffic(input int upto);
		int pick;
		int n;
		logic [7:0] cmd;
		while (items_sent < upto) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 255) : $urandom_range(0, 24);
				case ($urandom_range(0, 9))
					0: cmd = LAST_CMD_A;
					1: cmd = LAST_CMD_B;
					default: cmd = 8'($urandom);
				endcase
				send_packet(n, cmd, $urandom_range(0, 9) == 0,
					($urandom_range(0, 11) == 0) ? $urandom_range(1, n + 4) : 0);
			end else if (pick < 82) begin
				send_item(OP_READ, 8'($urandom),
					($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40)));
			end else if (pick < 87) begin
				send_item(OP_CLEAR, 8'($urandom), 9'($urandom));
			end else if (pick < 90) begin
				send_item(OP_NONE, 8'($urandom), 9'($urandom));
			end else begin
				send_item(OP_PUSH, 8'($urandom), 9'($urandom));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad starts, unused opcode, reads of an empty table
		send_item(OP_PUSH, 8'h00, 9'h000);
		send_item(OP_PUSH, 8'hff, 9'h1ff);
		send_item(OP_NONE, 8'hff, 9'h1ff);
		send_item(OP_READ, 8'h00, 9'h000);
		send_item(OP_READ, 8'hff, 9'h1ff);
		// one full record plus a trailing partial one
		send_packet(5, 8'h00, 1'b0, 0);
		send_item(OP_READ, 8'h00, 9'd0);
		send_item(OP_READ, 8'h00, 9'd1);
		send_item(OP_READ, 8'h00, 9'd2);
		// shortest frame, closes the set
		send_packet(0, LAST_CMD_A, 1'b0, 0);
		send_item(OP_CLEAR, 8'h00, 9'h000);

		send_idle = 15;
		recv_idle = 48;
		random_traffic(items_sent + 40);

		// fill the table past its capacity
		send_item(OP_CLEAR, 8'h00, 9'h000);
		repeat (3)
			send_packet(255, 8'h00, 1'b0, 0);
		send_idle = 48;
		recv_idle = 15;
		repeat (3)
			send_packet(255, 8'h00, 1'b0, 0);
		send_packet(12, 8'h00, 1'b0, 0);
		repeat (16)
			send_item(OP_READ, 8'($urandom), 9'($urandom));
		send_item(OP_READ, 8'h00, 9'h1ff);
		send_packet(3, LAST_CMD_B, 1'b0, 0);

		send_idle = 0;
		recv_idle = 0;
		random_traffic(items_sent + 40);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
